/* hw/rtl/pimp_pkg.sv */
// Package for the point-in-multipolygon test: widths, register codes and the
// structs that travel between pipeline stages. No dependencies.
package pimp_pkg;

    localparam int COORD_BITS        = 32;
    localparam int LAT_BITS          = COORD_BITS - 1;
    localparam int DIFF_W            = COORD_BITS + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int CROSS_W           = PROD_W + 1;
    localparam int MIN_RING_VERTICES = 4;
    localparam int CNT_W             = $clog2(MIN_RING_VERTICES + 1);
    localparam int TOL_W             = 20;
    localparam int CFG_IDX_W         = 2;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(10000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_LON = 2'd0,
        CFG_QUERY_LAT = 2'd1,
        CFG_EDGE_TOL  = 2'd2
    } t_cfg_idx;

    // offsets of the query point against both edge ends, plus the edge vector
    typedef struct packed {
        logic signed [DIFF_W-1:0] ex_a;
        logic signed [DIFF_W-1:0] ex_b;
        logic signed [DIFF_W-1:0] ey_a;
        logic signed [DIFF_W-1:0] ey_b;
        logic signed [DIFF_W-1:0] dbx;
        logic signed [DIFF_W-1:0] dby;
    } t_edge_diff;

    typedef struct packed {
        logic signed [CROSS_W-1:0] xprod;
        logic                      in_box;
        logic                      cross_y;
        logic                      up;
    } t_edge_res;

    typedef struct packed {
        logic start;
        logic end_ring;
        logic end_poly;
        logic end_feat;
        logic outer;
        logic short_ring;
    } t_ctl;

endpackage

/* hw/rtl/pimp_vtx_track.sv */
// Vertex tracker: ring start/close bookkeeping and an offset register for each
// edge unit. Depends on pimp_pkg.
module pimp_vtx_track import pimp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic [COORD_BITS-1:0] i_vertex_lon,
    input  logic [LAT_BITS-1:0]   i_vertex_lat,
    input  logic                  i_first_in_ring,
    input  logic                  i_last_in_ring,
    input  logic                  i_outer_ring,
    input  logic                  i_last_in_polygon,
    input  logic                  i_last_in_feature,
    input  logic [COORD_BITS-1:0] i_query_lon,
    input  logic [LAT_BITS-1:0]   i_query_lat,
    output t_edge_diff            o_diff1,
    output t_edge_diff            o_diff2,
    output t_ctl                  o_ctl
);

    logic [COORD_BITS-1:0] r_first_lon, r_prev_lon;
    logic [LAT_BITS-1:0]   r_first_lat, r_prev_lat;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_edge_diff            r_diff1, r_diff2, n_diff1, n_diff2;
    t_ctl                  r_ctl, n_ctl;

    logic                     start, end_ring, end_poly;
    logic [CNT_W-1:0]         cnt_base, cnt_inc;
    logic signed [DIFF_W-1:0] qx, qy, vx, vy, px, py, fx, fy;

    function automatic logic signed [DIFF_W-1:0] ext_lon(input logic [COORD_BITS-1:0] v);
        return {{(DIFF_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [DIFF_W-1:0] ext_lat(input logic [LAT_BITS-1:0] v);
        return {{(DIFF_W-LAT_BITS){v[LAT_BITS-1]}}, v};
    endfunction

    function automatic t_edge_diff mk_diff(
        input logic signed [DIFF_W-1:0] x, input logic signed [DIFF_W-1:0] y,
        input logic signed [DIFF_W-1:0] ax, input logic signed [DIFF_W-1:0] ay,
        input logic signed [DIFF_W-1:0] bx, input logic signed [DIFF_W-1:0] by);
        t_edge_diff d;
        d.ex_a = x - ax;
        d.ex_b = x - bx;
        d.ey_a = y - ay;
        d.ey_b = y - by;
        d.dbx  = bx - ax;
        d.dby  = by - ay;
        return d;
    endfunction

    always_comb begin
        end_poly = i_last_in_polygon | i_last_in_feature;
        end_ring = i_last_in_ring | end_poly;
        start    = i_first_in_ring | (r_cnt == '0);
        cnt_base = start ? '0 : r_cnt;
        cnt_inc  = (cnt_base < CNT_W'(MIN_RING_VERTICES)) ? cnt_base + 1'b1 : cnt_base;
        n_cnt    = end_ring ? '0 : cnt_inc;

        qx = ext_lon(i_query_lon);
        qy = ext_lat(i_query_lat);
        vx = ext_lon(i_vertex_lon);
        vy = ext_lat(i_vertex_lat);
        px = ext_lon(r_prev_lon);
        py = ext_lat(r_prev_lat);
        fx = start ? vx : ext_lon(r_first_lon);
        fy = start ? vy : ext_lat(r_first_lat);

        n_diff1 = mk_diff(qx, qy, px, py, vx, vy);
        n_diff2 = mk_diff(qx, qy, vx, vy, fx, fy);

        n_ctl.start      = start;
        n_ctl.end_ring   = end_ring;
        n_ctl.end_poly   = end_poly;
        n_ctl.end_feat   = i_last_in_feature;
        n_ctl.outer      = i_outer_ring;
        n_ctl.short_ring = cnt_inc < CNT_W'(MIN_RING_VERTICES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_first_lon <= '0;
            r_first_lat <= '0;
            r_prev_lon  <= '0;
            r_prev_lat  <= '0;
        end else if (i_acc) begin
            r_cnt      <= n_cnt;
            r_prev_lon <= i_vertex_lon;
            r_prev_lat <= i_vertex_lat;
            if (start) begin
                r_first_lon <= i_vertex_lon;
                r_first_lat <= i_vertex_lat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_diff1 <= n_diff1;
            r_diff2 <= n_diff2;
            r_ctl   <= n_ctl;
        end
    end

    assign o_diff1 = r_diff1;
    assign o_diff2 = r_diff2;
    assign o_ctl   = r_ctl;

endmodule

/* hw/rtl/pimp_edge_unit.sv */
// Edge unit: two products, then the cross product, with box and straddle
// flags carried alongside. Depends on pimp_pkg.
module pimp_edge_unit import pimp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_ld_mul,
    input  logic       i_ld_sub,
    input  t_edge_diff i_diff,
    output t_edge_res  o_res
);

    logic signed [PROD_W-1:0]  r_p1, r_p2, n_p1, n_p2;
    logic                      r_box, r_cy, r_up, n_box, n_cy, n_up;
    t_edge_res                 r_res, n_res;

    always_comb begin
        n_p1  = $signed(i_diff.ex_a) * $signed(i_diff.dby);
        n_p2  = $signed(i_diff.ey_a) * $signed(i_diff.dbx);
        n_box = (!i_diff.ex_a[DIFF_W-1] | !i_diff.ex_b[DIFF_W-1])
              & (i_diff.ex_a[DIFF_W-1] | (i_diff.ex_a == '0)
                 | i_diff.ex_b[DIFF_W-1] | (i_diff.ex_b == '0))
              & (!i_diff.ey_a[DIFF_W-1] | !i_diff.ey_b[DIFF_W-1])
              & (i_diff.ey_a[DIFF_W-1] | (i_diff.ey_a == '0)
                 | i_diff.ey_b[DIFF_W-1] | (i_diff.ey_b == '0));
        n_cy  = i_diff.ey_a[DIFF_W-1] ^ i_diff.ey_b[DIFF_W-1];
        n_up  = !i_diff.dby[DIFF_W-1] & (i_diff.dby != '0);

        n_res.xprod   = CROSS_W'(r_p1) - CROSS_W'(r_p2);
        n_res.in_box  = r_box;
        n_res.cross_y = r_cy;
        n_res.up      = r_up;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_mul) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_box <= n_box;
            r_cy  <= n_cy;
            r_up  <= n_up;
        end
        if (i_ld_sub) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* hw/rtl/pimp_ring_acc.sv */
// Ring, polygon and feature accumulation plus the result register.
// Depends on pimp_pkg.
module pimp_ring_acc import pimp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  t_ctl             i_ctl,
    input  t_edge_res        i_res1,
    input  t_edge_res        i_res2,
    input  logic [TOL_W-1:0] i_tol,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_inside_res,
    output logic             o_short_ring_seen
);

    logic r_par, r_oe, r_poly, r_feat, r_short, r_out_valid;
    logic n_par, n_oe, n_poly, n_feat, n_short, n_out_valid;
    logic r_inside, r_short_out;

    logic on1, on2, hit1, hit2, par, oe, ring_in, poly;
    logic signed [CROSS_W-1:0] tol_s;

    function automatic logic edge_hit(input t_edge_res r);
        logic neg, zero;
        neg  = r.xprod[CROSS_W-1];
        zero = (r.xprod == '0);
        return r.cross_y & (r.up ? neg : (!neg & !zero));
    endfunction

    always_comb begin
        tol_s = $signed(CROSS_W'(i_tol));
        on1   = i_res1.in_box & (i_res1.xprod <= tol_s) & (i_res1.xprod >= -tol_s);
        on2   = i_res2.in_box & (i_res2.xprod <= tol_s) & (i_res2.xprod >= -tol_s);
        hit1  = edge_hit(i_res1);
        hit2  = edge_hit(i_res2);

        par = i_ctl.start ? 1'b0 : r_par ^ hit1;
        oe  = i_ctl.start ? 1'b0 : r_oe | on1;
        if (i_ctl.end_ring) begin
            par = par ^ hit2;
            oe  = oe | on2;
        end

        ring_in = !i_ctl.short_ring & (oe | par);
        poly    = r_poly;
        n_short = r_short;
        n_par   = par;
        n_oe    = oe;
        if (i_ctl.end_ring) begin
            n_par = 1'b0;
            n_oe  = 1'b0;
            if (i_ctl.short_ring) begin
                n_short = 1'b1;
            end
            if (i_ctl.outer) begin
                poly = ring_in;
            end else if (ring_in) begin
                poly = 1'b0;
            end
        end
        n_poly = poly;
        n_feat = r_feat;
        if (i_ctl.end_poly) begin
            n_feat = r_feat | poly;
            n_poly = 1'b0;
        end
        if (i_ctl.end_feat) begin
            n_feat  = 1'b0;
            n_short = 1'b0;
        end

        n_out_valid = r_out_valid & !i_out_ready;
        if (i_adv & i_ctl.end_feat) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par       <= 1'b0;
            r_oe        <= 1'b0;
            r_poly      <= 1'b0;
            r_feat      <= 1'b0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_adv) begin
                r_par   <= n_par;
                r_oe    <= n_oe;
                r_poly  <= n_poly;
                r_feat  <= n_feat;
                r_short <= n_short;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv & i_ctl.end_feat) begin
            r_inside    <= r_feat | (i_ctl.end_poly & poly);
            r_short_out <= r_short | (i_ctl.end_ring & i_ctl.short_ring);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_inside_res      = r_inside;
    assign o_short_ring_seen = r_short_out;

endmodule

/* hw/rtl/point_in_multipolygon_test.sv */
// Top level of the point-in-multipolygon test: config registers, pipeline
// valid chain, tracker, the step and closing edge units and the accumulator.
// Depends on pimp_pkg, pimp_vtx_track, pimp_edge_unit, pimp_ring_acc.
//
//   channel | valid / ready           | payload
//   --------+-------------------------+---------------------------------------
//   in      | i_in_valid / o_in_ready | vertex lon/lat, ring/polygon/feature marks
//   out     | o_out_valid/ i_out_ready| o_inside_res, o_short_ring_seen
//   cfg     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// One vertex per cycle while no held result stalls; a result is offered after
// the vertex that ends the feature passes products, cross, then accumulate.
// Both edges of a step (previous-to-current and ring closing) run in their own
// edge unit, so the rate is not affected by the closing edge.
// Reset is synchronous, active low, and clears the valid chain and all ring state.
// A held result stalls the accumulate stage only while it holds the vertex that ends a
// feature; the vertices behind it then wait, and the pipeline stalls stage by stage.
module point_in_multipolygon_test import pimp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_vertex_lon,
    input  logic [LAT_BITS-1:0]   i_vertex_lat,
    input  logic                  i_first_in_ring,
    input  logic                  i_last_in_ring,
    input  logic                  i_outer_ring,
    input  logic                  i_last_in_polygon,
    input  logic                  i_last_in_feature,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_inside_res,
    output logic                  o_short_ring_seen,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_data
);

    logic [COORD_BITS-1:0] r_query_lon;
    logic [LAT_BITS-1:0]   r_query_lat;
    logic [TOL_W-1:0]      r_tol;

    logic r_v1, r_v2, r_v3;
    t_ctl r_ctl2, r_ctl3, ctl1;
    logic acc, ld2, ld3, adv;

    t_edge_diff diff1, diff2;
    t_edge_res  res1, res2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_lon <= '0;
            r_query_lat <= '0;
            r_tol       <= TOL_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_QUERY_LON: r_query_lon <= i_cfg_data;
                CFG_QUERY_LAT: r_query_lat <= i_cfg_data[LAT_BITS-1:0];
                CFG_EDGE_TOL:  r_tol       <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        adv        = r_v3 & (!r_ctl3.end_feat | !o_out_valid | i_out_ready);
        ld3        = r_v2 & (!r_v3 | adv);
        ld2        = r_v1 & (!r_v2 | ld3);
        o_in_ready = !r_v1 | ld2;
        acc        = i_in_valid & o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= acc | (r_v1 & !ld2);
            r_v2 <= ld2 | (r_v2 & !ld3);
            r_v3 <= ld3 | (r_v3 & !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_ctl2 <= ctl1;
        end
        if (ld3) begin
            r_ctl3 <= r_ctl2;
        end
    end

    pimp_vtx_track u_track (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_acc             (acc),
        .i_vertex_lon      (i_vertex_lon),
        .i_vertex_lat      (i_vertex_lat),
        .i_first_in_ring   (i_first_in_ring),
        .i_last_in_ring    (i_last_in_ring),
        .i_outer_ring      (i_outer_ring),
        .i_last_in_polygon (i_last_in_polygon),
        .i_last_in_feature (i_last_in_feature),
        .i_query_lon       (r_query_lon),
        .i_query_lat       (r_query_lat),
        .o_diff1           (diff1),
        .o_diff2           (diff2),
        .o_ctl             (ctl1)
    );

    pimp_edge_unit u_edge_step (
        .i_clk    (i_clk),
        .i_ld_mul (ld2),
        .i_ld_sub (ld3),
        .i_diff   (diff1),
        .o_res    (res1)
    );

    pimp_edge_unit u_edge_close (
        .i_clk    (i_clk),
        .i_ld_mul (ld2),
        .i_ld_sub (ld3),
        .i_diff   (diff2),
        .o_res    (res2)
    );

    pimp_ring_acc u_acc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_adv             (adv),
        .i_ctl             (r_ctl3),
        .i_res1            (res1),
        .i_res2            (res2),
        .i_tol             (r_tol),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_inside_res      (o_inside_res),
        .o_short_ring_seen (o_short_ring_seen)
    );

endmodule
